// File: hw/rtl/assert_macros.svh
// Concurrent assertion helpers, clocked and disabled in reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPL(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

`define ASSERT_NEXT(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

// File: hw/rtl/gmspc_pkg.sv
package gmspc_pkg;

   localparam int MAX_SIDE_DEF = 128;
   localparam int SCORE_W      = 12;
   localparam int PATHS_W      = 30;
   localparam int DIGIT_W      = 4;
   localparam int CSR_W        = 8;

   localparam logic [PATHS_W-1:0] PATH_MOD   = 30'd1000000007;
   localparam logic [SCORE_W-1:0] SCORE_MAX  = 12'hFFF;
   localparam logic [CSR_W-1:0]   SIDE_RESET = 8'd128;

   typedef struct packed {
      logic [DIGIT_W-1:0] cell_digit;
      logic               cell_blocked;
   } req_type;

   typedef struct packed {
      logic [SCORE_W-1:0] cell_score;
      logic [PATHS_W-1:0] cell_paths;
      logic               last_cell;
   } rsp_type;

   typedef struct packed {
      logic [SCORE_W-1:0] score;
      logic [PATHS_W-1:0] paths;
   } cell_type;

   typedef struct packed {
      logic               first;
      logic               row0;
      logic               col0;
      logic               blocked;
      logic [DIGIT_W-1:0] digit;
   } calc_ctl_type;

endpackage

// File: hw/rtl/gmspc_line_mem.sv
module gmspc_line_mem #(
   parameter int DEPTH = gmspc_pkg::MAX_SIDE_DEF
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [$clog2(DEPTH)-1:0]       wr_addr,
   input  gmspc_pkg::cell_type            wr_data,
   input  logic                           rd_en,
   input  logic [$clog2(DEPTH)-1:0]       rd_addr,
   output gmspc_pkg::cell_type            rd_data
);

   gmspc_pkg::cell_type mem [DEPTH];
   gmspc_pkg::cell_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/gmspc_cell_calc.sv
module gmspc_cell_calc (
   input  gmspc_pkg::calc_ctl_type ctl,
   input  gmspc_pkg::cell_type     up,
   input  gmspc_pkg::cell_type     left,
   input  gmspc_pkg::cell_type     diag,
   output gmspc_pkg::cell_type     res
);

   localparam int SUM_W = gmspc_pkg::PATHS_W + 2;

   logic                            up_ok;
   logic                            left_ok;
   logic                            diag_ok;
   logic [gmspc_pkg::SCORE_W-1:0]   best;
   logic [SUM_W-1:0]                sum;
   logic [SUM_W-1:0]                mod1;
   logic [SUM_W-1:0]                mod2;
   logic [gmspc_pkg::SCORE_W:0]     score_sum;

   always_comb begin
      up_ok   = !ctl.row0 && (up.paths != '0);
      left_ok = !ctl.col0 && (left.paths != '0);
      diag_ok = !ctl.row0 && !ctl.col0 && (diag.paths != '0);

      best = '0;
      if (up_ok && up.score > best) begin
         best = up.score;
      end
      if (left_ok && left.score > best) begin
         best = left.score;
      end
      if (diag_ok && diag.score > best) begin
         best = diag.score;
      end

      sum = '0;
      if (up_ok && up.score == best) begin
         sum = sum + SUM_W'(up.paths);
      end
      if (left_ok && left.score == best) begin
         sum = sum + SUM_W'(left.paths);
      end
      if (diag_ok && diag.score == best) begin
         sum = sum + SUM_W'(diag.paths);
      end

      mod1 = SUM_W'(gmspc_pkg::PATH_MOD);
      mod2 = {mod1[SUM_W-2:0], 1'b0};
      if (sum >= mod2) begin
         sum = sum - mod2;
      end else if (sum >= mod1) begin
         sum = sum - mod1;
      end

      score_sum = {1'b0, best} + (gmspc_pkg::SCORE_W+1)'(ctl.digit);

      res = '0;
      if (ctl.first) begin
         res.paths = gmspc_pkg::PATHS_W'(1);
      end else if (!ctl.blocked && (up_ok || left_ok || diag_ok)) begin
         res.score = score_sum[gmspc_pkg::SCORE_W] ? gmspc_pkg::SCORE_MAX
                                                   : score_sum[gmspc_pkg::SCORE_W-1:0];
         res.paths = sum[gmspc_pkg::PATHS_W-1:0];
      end
   end

endmodule

// File: hw/rtl/grid_max_score_path_count.sv
// Channel   Ports            Carries
// req       req_valid/ready  one grid cell: digit, blocked flag
// rsp       rsp_valid/ready  score, path count mod 1e9+7, last cell
// csr       csr_valid/ready  grid side, restarts the scan
//
// One cell per cycle unless rsp stalls; cells pass the compute and output registers.
// The line memory read is issued at the req transfer and used in the compute stage;
// a write to the same column in the read's cycle is forwarded into the read data.
// Reset clears the scan position, pipeline valids and sets the side to 128.
// A stalled rsp holds the output register; one more cell waits in the compute stage.
`include "assert_macros.svh"

module grid_max_score_path_count #(
   parameter int MAX_SIDE = gmspc_pkg::MAX_SIDE_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  gmspc_pkg::req_type            req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output gmspc_pkg::rsp_type            rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [gmspc_pkg::CSR_W-1:0]   csr_data
);

   localparam int IDX_W  = $clog2(MAX_SIDE);
   localparam int SIDE_W = $clog2(MAX_SIDE + 1);
   localparam int CMP_W  = (SIDE_W > gmspc_pkg::CSR_W) ? SIDE_W : gmspc_pkg::CSR_W;

   logic [gmspc_pkg::CSR_W-1:0] side_ff,  side_in;
   logic [IDX_W-1:0]            row_ff,   row_in;
   logic [IDX_W-1:0]            col_ff,   col_in;

   logic                        s1_valid_ff, s1_valid_in;
   gmspc_pkg::calc_ctl_type     s1_ctl_ff,   s1_ctl_in;
   logic [IDX_W-1:0]            s1_addr_ff,  s1_addr_in;
   logic                        s1_last_ff,  s1_last_in;

   gmspc_pkg::cell_type         left_ff,  left_in;
   gmspc_pkg::cell_type         diag_ff,  diag_in;

   logic                        out_valid_ff, out_valid_in;
   gmspc_pkg::rsp_type          out_data_ff,  out_data_in;

   logic [CMP_W-1:0]            side_wide;
   logic [SIDE_W-1:0]           side_eff;
   logic [IDX_W-1:0]            side_m1;
   logic                        row_end;
   logic                        col_end;
   logic                        req_xfer;
   logic                        csr_xfer;
   logic                        s1_advance;
   gmspc_pkg::cell_type         mem_rd;
   gmspc_pkg::cell_type         up_used;
   gmspc_pkg::cell_type         res;

   always_comb begin
      side_wide = CMP_W'(side_ff);
      if (side_wide == '0) begin
         side_eff = SIDE_W'(1);
      end else if (side_wide > CMP_W'(MAX_SIDE)) begin
         side_eff = SIDE_W'(MAX_SIDE);
      end else begin
         side_eff = SIDE_W'(side_wide);
      end
      side_m1 = IDX_W'(side_eff - SIDE_W'(1));
      row_end = (row_ff == side_m1);
      col_end = (col_ff == side_m1);
   end

   assign s1_advance = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign req_xfer   = req_valid && req_ready;
   assign csr_ready  = 1'b1;
   assign csr_xfer   = csr_valid;

   assign up_used = s1_ctl_ff.row0 ? '0 : mem_rd;

   gmspc_line_mem #(
      .DEPTH (MAX_SIDE)
   ) u_line_mem (
      .clock   (clock),
      .wr_en   (s1_advance),
      .wr_addr (s1_addr_ff),
      .wr_data (res),
      .rd_en   (req_xfer),
      .rd_addr (col_ff),
      .rd_data (mem_rd)
   );

   gmspc_cell_calc u_cell_calc (
      .ctl  (s1_ctl_ff),
      .up   (up_used),
      .left (left_ff),
      .diag (diag_ff),
      .res  (res)
   );

   always_comb begin
      side_in = side_ff;
      row_in  = row_ff;
      col_in  = col_ff;
      if (csr_xfer) begin
         side_in = csr_data;
         row_in  = '0;
         col_in  = '0;
      end else if (req_xfer) begin
         if (col_end) begin
            col_in = '0;
            row_in = row_end ? '0 : row_ff + IDX_W'(1);
         end else begin
            col_in = col_ff + IDX_W'(1);
         end
      end

      s1_valid_in = req_xfer || (s1_valid_ff && !s1_advance);
      s1_ctl_in   = s1_ctl_ff;
      s1_addr_in  = s1_addr_ff;
      s1_last_in  = s1_last_ff;
      if (req_xfer) begin
         s1_ctl_in.first   = (row_ff == '0) && (col_ff == '0);
         s1_ctl_in.row0    = (row_ff == '0);
         s1_ctl_in.col0    = (col_ff == '0);
         s1_ctl_in.blocked = req_data.cell_blocked;
         s1_ctl_in.digit   = req_data.cell_digit;
         s1_addr_in        = col_ff;
         s1_last_in        = row_end && col_end;
      end

      left_in     = left_ff;
      diag_in     = diag_ff;
      out_data_in = out_data_ff;
      if (s1_advance) begin
         left_in                = res;
         diag_in                = up_used;
         out_data_in.cell_score = res.score;
         out_data_in.cell_paths = res.paths;
         out_data_in.last_cell  = s1_last_ff;
      end
      out_valid_in = s1_advance || (out_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff      <= gmspc_pkg::SIDE_RESET;
         row_ff       <= '0;
         col_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         left_ff      <= '0;
         diag_ff      <= '0;
      end else begin
         side_ff      <= side_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         left_ff      <= left_in;
         diag_ff      <= diag_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ctl_ff   <= s1_ctl_in;
      s1_addr_ff  <= s1_addr_in;
      s1_last_ff  <= s1_last_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   `ASSERT_IMPL(a_pos_in_grid, clock, reset, 1'b1,
      (SIDE_W'(row_ff) < side_eff) && (SIDE_W'(col_ff) < side_eff),
      "scan position outside grid")
   `ASSERT_IMPL(a_paths_reduced, clock, reset, out_valid_ff,
      out_data_ff.cell_paths < gmspc_pkg::PATH_MOD, "path count not reduced")
   `ASSERT_NEXT(a_last_wraps, clock, reset, req_xfer && row_end && col_end,
      (row_ff == '0) && (col_ff == '0), "scan did not wrap after last cell")
   `ASSERT_NEXT(a_first_start, clock, reset, req_xfer && (row_ff == '0) && (col_ff == '0),
      s1_ctl_ff.first, "start cell not flagged")

endmodule

// File: tb/grid_max_score_path_count_tb.sv
module grid_max_score_path_count_tb;

   typedef struct {
      bit                 is_side;
      logic [7:0]         side;
      logic [3:0]         digit;
      logic               blocked;
      bit                 known;
      gmspc_pkg::rsp_type want;
   } plan_row_type;

   localparam longint unsigned PATH_MODULUS = 64'd1000000007;
   localparam int unsigned     SCORE_CEIL   = 4095;

   logic                  clock;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   gmspc_pkg::req_type    req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   gmspc_pkg::rsp_type    rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [7:0]            csr_data  = '0;

   gmspc_pkg::cell_type   prev_row [gmspc_pkg::MAX_SIDE_DEF];
   gmspc_pkg::cell_type   left_nb;
   gmspc_pkg::cell_type   diag_nb;
   int unsigned           cur_row;
   int unsigned           cur_col;
   int unsigned           side_reg;

   gmspc_pkg::rsp_type    cell_results_due [$];
   plan_row_type          directed_plan [$];
   int unsigned           mismatch_count;
   int unsigned           cells_sent;
   int unsigned           cells_checked;
   int unsigned           grids_done;
   int unsigned           side_writes;
   int unsigned           top_score;
   int unsigned           top_paths;
   int unsigned           rsp_hold;
   bit                    req_calm;
   bit                    rsp_calm;

   grid_max_score_path_count i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic gmspc_pkg::rsp_type score_cell(input logic [3:0] digit,
                                                     input logic blocked);
      int unsigned         span;
      int unsigned         best;
      longint unsigned     total;
      bit                  found;
      gmspc_pkg::cell_type up;
      gmspc_pkg::cell_type res;
      gmspc_pkg::cell_type nb [3];
      bit                  use_nb [3];
      gmspc_pkg::rsp_type  out;
      span = (side_reg == 0) ? 1 : ((side_reg > gmspc_pkg::MAX_SIDE_DEF) ?
             gmspc_pkg::MAX_SIDE_DEF : side_reg);
      up = '0;
      res = '0;
      best = 0;
      total = 0;
      found = 1'b0;
      if (cur_row > 0) up = prev_row[cur_col];
      if (cur_row == 0 && cur_col == 0) begin
         res.score = '0;
         res.paths = 30'(1);
      end else if (!blocked) begin
         nb[0] = up;
         nb[1] = left_nb;
         nb[2] = diag_nb;
         use_nb[0] = (cur_row > 0);
         use_nb[1] = (cur_col > 0);
         use_nb[2] = (cur_row > 0) && (cur_col > 0);
         for (int k = 0; k < 3; k++) begin
            if (use_nb[k] && nb[k].paths != 0) begin
               if (!found || 32'(nb[k].score) > best) begin
                  best = 32'(nb[k].score);
                  total = 64'(nb[k].paths);
                  found = 1'b1;
               end else if (32'(nb[k].score) == best) begin
                  total += 64'(nb[k].paths);
               end
            end
         end
         if (found) begin
            res.score = 12'((best + 32'(digit) > SCORE_CEIL) ? SCORE_CEIL
                                                             : best + 32'(digit));
            res.paths = 30'(total % PATH_MODULUS);
         end
      end
      diag_nb = up;
      prev_row[cur_col] = res;
      left_nb = res;
      out.cell_score = res.score;
      out.cell_paths = res.paths;
      out.last_cell = (cur_row + 1 >= span) && (cur_col + 1 >= span);
      if (cur_col + 1 >= span) begin
         cur_col = 0;
         cur_row = (cur_row + 1 >= span) ? 0 : cur_row + 1;
      end else begin
         cur_col = cur_col + 1;
      end
      return out;
   endfunction

   function automatic void plan_side(input logic [7:0] side);
      plan_row_type row;
      row = '{default: '0};
      row.is_side = 1'b1;
      row.side = side;
      directed_plan.push_back(row);
   endfunction

   function automatic void plan_cell(input logic [3:0] digit, input logic blocked,
                                     input bit known, input int unsigned score,
                                     input int unsigned paths, input bit last);
      plan_row_type row;
      row = '{default: '0};
      row.digit = digit;
      row.blocked = blocked;
      row.known = known;
      row.want.cell_score = 12'(score);
      row.want.cell_paths = 30'(paths);
      row.want.last_cell = last;
      directed_plan.push_back(row);
   endfunction

   task automatic send_cell(input logic [3:0] digit, input logic blocked,
                            input bit known, input gmspc_pkg::rsp_type want);
      int unsigned        gap;
      gmspc_pkg::req_type item;
      gmspc_pkg::rsp_type predicted;
      gap = req_calm ? 0 : $urandom_range(0, 14);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      item.cell_digit = digit;
      item.cell_blocked = blocked;
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      predicted = score_cell(digit, blocked);
      cell_results_due.push_back(known ? want : predicted);
      cells_sent++;
   endtask

   task automatic write_side(input logic [7:0] side);
      req_valid <= 1'b0;
      while (cell_results_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= side;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      side_reg = 32'(side);
      cur_row = 0;
      cur_col = 0;
      side_writes++;
   endtask

   always @(posedge clock) begin
      int unsigned        hold_n;
      gmspc_pkg::rsp_type want;
      if (reset) begin
         rsp_hold <= 0;
         rsp_ready <= 1'b0;
      end else begin
         hold_n = (rsp_hold > 0) ? rsp_hold - 1 : 0;
         if (rsp_valid && rsp_ready) begin
            hold_n = rsp_calm ? 0 : $urandom_range(0, 14);
            if (cell_results_due.size() == 0) begin
               $display("%0t: unexpected transfer, got score %0d paths %0d last %0d",
                        $time, rsp_data.cell_score, rsp_data.cell_paths, rsp_data.last_cell);
               mismatch_count++;
            end else begin
               want = cell_results_due.pop_front();
               cells_checked++;
               if (rsp_data.cell_score !== want.cell_score) begin
                  $display("%0t: cell_score expected %0d, got %0d",
                           $time, want.cell_score, rsp_data.cell_score);
                  mismatch_count++;
               end
               if (rsp_data.cell_paths !== want.cell_paths) begin
                  $display("%0t: cell_paths expected %0d, got %0d",
                           $time, want.cell_paths, rsp_data.cell_paths);
                  mismatch_count++;
               end
               if (rsp_data.last_cell !== want.last_cell) begin
                  $display("%0t: last_cell expected %0d, got %0d",
                           $time, want.last_cell, rsp_data.last_cell);
                  mismatch_count++;
               end
               if (want.last_cell) grids_done++;
               if (32'(want.cell_score) > top_score) top_score = 32'(want.cell_score);
               if (32'(want.cell_paths) > top_paths) top_paths = 32'(want.cell_paths);
            end
         end
         rsp_hold <= hold_n;
         rsp_ready <= (hold_n == 0);
      end
   end

   initial begin
      int unsigned        random_cells;
      int unsigned        pick;
      int unsigned        side;
      int unsigned        count;
      int unsigned        digit_top;
      int unsigned        block_odds;
      logic [3:0]         digit;
      logic               blocked;
      gmspc_pkg::rsp_type none;
      plan_row_type       row;

      none = '0;
      random_cells = 0;
      mismatch_count = 0;
      cells_sent = 0;
      cells_checked = 0;
      grids_done = 0;
      side_writes = 0;
      top_score = 0;
      top_paths = 0;
      req_calm = 1'b0;
      rsp_calm = 1'b0;
      left_nb = '0;
      diag_nb = '0;
      cur_row = 0;
      cur_col = 0;
      side_reg = 32'(gmspc_pkg::SIDE_RESET);
      foreach (prev_row[i]) prev_row[i] = '0;

      // start cell ignores its fields; row 0 beyond a block is unreachable
      plan_cell(4'd15, 1'b1, 1, 0, 1, 0);
      plan_cell(4'd9,  1'b0, 1, 9, 1, 0);
      plan_cell(4'd0,  1'b1, 1, 0, 0, 0);
      plan_cell(4'd5,  1'b0, 1, 0, 0, 0);
      plan_side(8'd1);
      plan_cell(4'd7,  1'b1, 1, 0, 1, 1);
      plan_cell(4'd0,  1'b0, 1, 0, 1, 1);
      plan_side(8'd0);
      plan_cell(4'd15, 1'b0, 1, 0, 1, 1);
      plan_side(8'd2);
      plan_cell(4'd0,  1'b0, 1, 0, 1, 0);
      plan_cell(4'd0,  1'b0, 1, 0, 1, 0);
      plan_cell(4'd0,  1'b0, 1, 0, 1, 0);
      plan_cell(4'd0,  1'b0, 1, 0, 3, 1);
      plan_cell(4'd3,  1'b0, 1, 0, 1, 0);
      plan_cell(4'd15, 1'b0, 1, 15, 1, 0);
      plan_cell(4'd4,  1'b0, 1, 4, 1, 0);
      plan_cell(4'd2,  1'b0, 1, 17, 1, 1);
      plan_side(8'd255);
      plan_cell(4'd0,  1'b0, 1, 0, 1, 0);
      plan_cell(4'd8,  1'b0, 1, 8, 1, 0);
      plan_cell(4'd9,  1'b0, 1, 17, 1, 0);
      plan_side(8'd3);
      plan_cell(4'd9,  1'b0, 0, 0, 0, 0);
      plan_cell(4'd1,  1'b0, 0, 0, 0, 0);
      plan_cell(4'd1,  1'b1, 0, 0, 0, 0);
      plan_cell(4'd2,  1'b0, 0, 0, 0, 0);
      plan_cell(4'd0,  1'b1, 0, 0, 0, 0);
      plan_cell(4'd6,  1'b0, 0, 0, 0, 0);
      plan_cell(4'd4,  1'b0, 0, 0, 0, 0);
      plan_cell(4'd3,  1'b0, 0, 0, 0, 0);
      plan_cell(4'd5,  1'b0, 0, 0, 0, 0);

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_plan[i]) begin
         row = directed_plan[i];
         req_calm = ($urandom_range(0, 2) == 0);
         if (row.is_side) write_side(row.side);
         else send_cell(row.digit, row.blocked, row.known, row.want);
      end

      // open with a wide partial grid so the line store is used across its depth
      pick = 4;
      while (random_cells < 1400) begin
         req_calm = ($urandom_range(0, 3) == 0);
         rsp_calm = ($urandom_range(0, 3) == 0);
         digit_top = ($urandom_range(0, 2) == 0) ? 1 : (($urandom_range(0, 2) == 0) ? 15 : 9);
         block_odds = ($urandom_range(0, 1) == 0) ? 8 : 3;
         if (random_cells == 0) begin
            side = gmspc_pkg::MAX_SIDE_DEF;
            count = 2 * gmspc_pkg::MAX_SIDE_DEF + 20;
         end else if (pick == 0) begin
            side = $urandom_range(0, 1);
            count = $urandom_range(1, 6);
         end else if (pick == 1) begin
            side = $urandom_range(129, 255);
            count = $urandom_range(130, 260);
         end else if (pick <= 3) begin
            side = $urandom_range(14, 17);
            count = side * side;
            digit_top = 0;
            block_odds = 0;
         end else begin
            side = $urandom_range(2, 12);
            count = side * side * $urandom_range(1, 3);
            if ($urandom_range(0, 3) == 0) count += $urandom_range(1, side * side - 1);
         end
         write_side(8'(side));
         repeat (count) begin
            digit = 4'($urandom_range(0, digit_top));
            blocked = (block_odds != 0) && ($urandom_range(0, block_odds - 1) == 0);
            send_cell(digit, blocked, 0, none);
            random_cells++;
         end
         pick = $urandom_range(0, 19);
      end

      req_valid <= 1'b0;
      while (cell_results_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Run covered %0d cells (%0d results checked), %0d finished grids, %0d side writes",
               cells_sent, cells_checked, grids_done, side_writes);
      $display("Highest score %0d, highest path count %0d, %0d mismatches",
               top_score, top_paths, mismatch_count);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
